// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: opcodes, status codes,
// controller/datapath command and status bundles, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    // Default build sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths fixed by the interface
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 5;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } cdq_op_t;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted transaction
        logic exec;     // perform the operation, update pointers
        logic capture;  // take the slot read data into the result
    } cdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_needed; // current operation reads a slot
    } cdq_stat_t;

endpackage : cdq_pkg

`default_nettype wire

// ===== rtl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule : cdq_ram

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: accepts one transaction, runs the operation,
// waits for slot read data when needed, then holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (stat.rd_needed)
                    begin
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        state_reg     <= ST_RESP;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_FETCH:
                begin
                    state_reg     <= ST_RESP;
                    out_valid_reg <= 1'b1;
                end
                ST_RESP:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath commands
    always_comb
    begin
        cmd.load    = in_valid && in_ready_reg;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.capture = (state_reg == ST_FETCH);
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule : cdq_ctrl

`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// Pointers, capacity register, slot store and result registers of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdq_pkg::cdq_cmd_t           cmd,
    output cdq_pkg::cdq_stat_t          stat,
    input  logic                        cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   cfg_data,
    input  logic [cdq_pkg::OP_W-1:0]    opcode,
    input  logic [DATA_WIDTH-1:0]       value,
    output logic [DATA_WIDTH-1:0]       data,
    output logic [cdq_pkg::STAT_W-1:0]  status,
    output logic                        is_empty,
    output logic                        is_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1) > 0 ? $clog2(DEPTH + 1) : 1;
    localparam int CAP_MAX = (DEPTH < (2 ** cdq_pkg::CAP_W) - 1) ?
                             DEPTH : (2 ** cdq_pkg::CAP_W) - 1;
    localparam logic [cdq_pkg::CAP_W-1:0] CAP_RESET = cdq_pkg::CAP_W'(CAP_MAX);

    // Registers
    logic [cdq_pkg::CAP_W-1:0]  capacity_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic                       empty_reg, empty_next;
    logic [cdq_pkg::OP_W-1:0]   op_reg;
    logic [DATA_WIDTH-1:0]      value_reg;
    logic [DATA_WIDTH-1:0]      data_reg;
    logic [cdq_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       is_empty_reg;
    logic                       is_full_reg;

    // Operation decode signals
    logic [CNT_W-1:0]           cap_eff;
    logic [PTR_W-1:0]           cap_last;
    logic [PTR_W-1:0]           head_dec, head_inc, tail_inc, tail_dec, tail_next_inc;
    logic                       full_now;
    logic                       full_next;
    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    logic [PTR_W-1:0]           rd_addr;
    logic                       rd_needed;
    logic [DATA_WIDTH-1:0]      ram_rdata;

    // Effective capacity: zero acts as one, clamp to the built depth
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(capacity_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    assign cap_last = PTR_W'(cap_eff - CNT_W'(1));

    // Ring pointer steps with wrap at the effective capacity
    assign head_inc      = (head_reg == cap_last) ? '0 : head_reg + PTR_W'(1);
    assign head_dec      = (head_reg == '0) ? cap_last : head_reg - PTR_W'(1);
    assign tail_inc      = (tail_reg == cap_last) ? '0 : tail_reg + PTR_W'(1);
    assign tail_dec      = (tail_reg == '0) ? cap_last : tail_reg - PTR_W'(1);
    assign tail_next_inc = (tail_next == cap_last) ? '0 : tail_next + PTR_W'(1);

    assign full_now  = !empty_reg && (head_reg == tail_inc);
    assign full_next = !empty_next && (head_next == tail_next_inc);

    // Operation: next pointers, slot access and status
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = cdq_pkg::STAT_DONE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = head_reg;
        rd_needed   = 1'b0;
        unique case (op_reg)
            cdq_pkg::OP_PUSH_FRONT,
            cdq_pkg::OP_PUSH_REAR:
            begin
                if (full_now)
                begin
                    status_next = cdq_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_addr    = '0;
                    end
                    else if (op_reg == cdq_pkg::OP_PUSH_FRONT)
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                    end
                end
            end
            cdq_pkg::OP_POP_FRONT,
            cdq_pkg::OP_POP_REAR,
            cdq_pkg::OP_PEEK_FRONT,
            cdq_pkg::OP_PEEK_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = cdq_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_needed = 1'b1;
                    if (op_reg == cdq_pkg::OP_POP_FRONT || op_reg == cdq_pkg::OP_PEEK_FRONT)
                    begin
                        rd_addr = head_reg;
                    end
                    else
                    begin
                        rd_addr = tail_reg;
                    end
                    // Pops move a pointer; the last entry empties the deque
                    if (op_reg == cdq_pkg::OP_POP_FRONT || op_reg == cdq_pkg::OP_POP_REAR)
                    begin
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (op_reg == cdq_pkg::OP_POP_FRONT)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            tail_next = tail_dec;
                        end
                    end
                end
            end
            default:
            begin
                // unknown opcode: no change
            end
        endcase
    end

    assign stat.rd_needed = rd_needed;

    // Capacity and pointer state; a capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // Transaction and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            data_reg     <= '0;
            status_reg   <= status_next;
            is_empty_reg <= empty_next;
            is_full_reg  <= full_next;
        end
        if (cmd.capture)
        begin
            data_reg <= ram_rdata;
        end
    end

    // Slot store
    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (cmd.exec && wr_en),
        .waddr (wr_addr),
        .wdata (value_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign data     = data_reg;
    assign status   = status_reg;
    assign is_empty = is_empty_reg;
    assign is_full  = is_full_reg;

endmodule : cdq_datapath

`default_nettype wire

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring of DEPTH slots, capacity set by register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode and value: push front,
//   push rear, pop front, pop rear, peek front, peek rear. Each transaction
//   yields exactly one result on the output channel (out_valid/out_ready)
//   with data, status (done, full, empty), is_empty and is_full.
//   One transaction is in flight at a time. out_valid rises after the EXEC
//   state for pushes and failed pops/peeks, after EXEC and FETCH for
//   pops and peeks that read a slot (the slot RAM has a registered read).
//   A new transaction is taken only after the result has been accepted
//   and the sequencer is back in its idle state.
//   While a result waits for out_ready, in_ready stays low and the result
//   holds steady.
//   cfg_we/cfg_data write the capacity register (taken at 0 as 1, clamped to
//   DEPTH); any write empties the deque. Write only while idle.
//   Reset: deque empty, capacity DEPTH (at most 31), ready for input at once. Slot
//   contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]         cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cdq_pkg::OP_W-1:0]          opcode,
    input  logic signed [DATA_WIDTH-1:0]      value,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      data,
    output logic [cdq_pkg::STAT_W-1:0]        status,
    output logic                              is_empty,
    output logic                              is_full
);

    cdq_pkg::cdq_cmd_t  cmd;
    cdq_pkg::cdq_stat_t stat;
    logic [DATA_WIDTH-1:0] data_raw;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .opcode   (opcode),
        .value    (value),
        .data     (data_raw),
        .status   (status),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    assign data = signed'(data_raw);

endmodule : circular_deque

`default_nettype wire
